/* sv/nnsb_pkg.sv */
// Shared types and constants of the nearest-neighbour set builder.
// No dependencies; every other file of the block but nnsb_ram imports this package.
`default_nettype none
package nnsb_pkg;

  // Field widths that the external interface fixes
  localparam int COST_W = 32;
  localparam int ROW_W  = 6;
  localparam int MASK_W = 64;

  // Configuration registers
  localparam int VC_W       = 7;
  localparam int NG_W       = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NG_SIZE      = 1'd1;

  localparam logic [VC_W-1:0] VC_RESET = 7'd64;
  localparam logic [NG_W-1:0] NG_RESET = 6'd8;

  // Defaults of the top-level parameters
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COST_BITS_DEF    = 32;

  // Effective configuration: clamped vertex count and clipped set size
  typedef struct packed {
    logic [VC_W-1:0] n;
    logic [NG_W-1:0] k;
  } cfg_t;

  // Request to the selection engine
  typedef struct packed {
    logic            start;
    logic [VC_W-1:0] n;
    logic [NG_W-1:0] k;
  } sel_req_t;

  // Response of the selection engine; mask holds after done until next start
  typedef struct packed {
    logic              done;
    logic [MASK_W-1:0] mask;
  } sel_rsp_t;

endpackage
`default_nettype wire

/* sv/nnsb_in_if.sv */
// Cost request channel: valid/ready handshake carrying one cost.
// Depends on nnsb_pkg.
`default_nettype none
interface nnsb_in_if;
  import nnsb_pkg::*;

  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;

  modport source (output valid, output cost, input ready);
  modport sink   (input valid, input cost, output ready);
endinterface
`default_nettype wire

/* sv/nnsb_out_if.sv */
// Result request channel: valid/ready handshake carrying row index and mask.
// Depends on nnsb_pkg.
`default_nettype none
interface nnsb_out_if;
  import nnsb_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row_index;
  logic [MASK_W-1:0] neighbor_mask;

  modport source (output valid, output row_index, output neighbor_mask, input ready);
  modport sink   (input valid, input row_index, input neighbor_mask, output ready);
endinterface
`default_nettype wire

/* sv/nnsb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module nnsb_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/nnsb_cfg.sv */
// APB-style configuration registers; derives the clamped vertex count and
// the clipped neighbourhood size. Depends on nnsb_pkg.
`default_nettype none
module nnsb_cfg #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [nnsb_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [nnsb_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [nnsb_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output nnsb_pkg::cfg_t                           cfg
);
  import nnsb_pkg::*;

  logic [VC_W-1:0]      vc_r, vc_nxt;
  logic [NG_W-1:0]      ng_r, ng_nxt;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [VC_W-1:0]      n_eff;
  logic [VC_W-1:0]      n_m1;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    vc_nxt = vc_r;
    ng_nxt = ng_r;
    if (wr_en) begin
      case (reg_idx)
        REG_VERTEX_COUNT: vc_nxt = pwdata[VC_W-1:0];
        REG_NG_SIZE:      ng_nxt = pwdata[NG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
      ng_r <= NG_RESET;
    end else begin
      vc_r <= vc_nxt;
      ng_r <= ng_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VERTEX_COUNT: prdata = CFG_DATA_W'(vc_r);
      REG_NG_SIZE:      prdata = CFG_DATA_W'(ng_r);
      default:          prdata = '0;
    endcase
  end

  // Clamp N to 2..MAX_VERTICES, clip k to N-1
  always_comb begin
    if (vc_r < VC_W'(2)) begin
      n_eff = VC_W'(2);
    end else if (vc_r > VC_W'(MAX_VERTICES)) begin
      n_eff = VC_W'(MAX_VERTICES);
    end else begin
      n_eff = vc_r;
    end
    n_m1  = n_eff - VC_W'(1);
    cfg.n = n_eff;
    cfg.k = (VC_W'(ng_r) > n_m1) ? n_m1[NG_W-1:0] : ng_r;
  end

endmodule
`default_nettype wire

/* sv/nnsb_select.sv */
// Selection engine: k passes over the stored row, each finding the cheapest
// vertex not yet chosen (lower index wins ties); k of 0 or N-1 needs no pass. Depends on nnsb_pkg.
`default_nettype none
module nnsb_select #(
  parameter int MAX_VERTICES = 64,
  parameter int COST_BITS    = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire nnsb_pkg::sel_req_t                req,
  output nnsb_pkg::sel_rsp_t                     rsp,
  output logic                                   ram_re,
  output logic      [$clog2(MAX_VERTICES)-1:0]   ram_raddr,
  input  wire logic [COST_BITS-1:0]              ram_rdata
);
  import nnsb_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } sel_st_t;

  sel_st_t                 st_r, st_nxt;
  logic [VC_W-1:0]         n_r, n_nxt;
  logic [NG_W-1:0]         k_r, k_nxt;
  logic [NG_W-1:0]         left_r, left_nxt;
  logic [AW-1:0]           rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]           rd_j_r, rd_j_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    best_vld_r, best_vld_nxt;
  logic [COST_BITS-1:0]    best_cost_r, best_cost_nxt;
  logic [AW-1:0]           best_j_r, best_j_nxt;
  logic [MAX_VERTICES-1:0] chosen_r, chosen_nxt;
  logic [MAX_VERTICES-1:0] all_mask;
  logic [VC_W-1:0]         n_m1;
  logic [VC_W-1:0]         req_n_m1;
  logic [AW-1:0]           last_idx;
  logic                    take;
  logic                    pass_end;
  logic [AW-1:0]           cand_j;

  assign n_m1     = n_r - VC_W'(1);
  assign req_n_m1 = req.n - VC_W'(1);
  assign last_idx = n_m1[AW-1:0];

  // Every vertex 1..N-1 when the whole row is the neighbourhood
  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      all_mask[j] = (j != 0) && (VC_W'(j) < req.n);
    end
  end

  assign take = (st_r == S_RUN) && rd_vld_r && !chosen_r[rd_j_r] &&
                (!best_vld_r || (ram_rdata < best_cost_r));
  assign pass_end = (st_r == S_RUN) && rd_vld_r && (rd_j_r == last_idx);
  assign cand_j   = take ? rd_j_r : best_j_r;

  assign ram_re    = (st_r == S_RUN);
  assign ram_raddr = rd_idx_r;

  always_comb begin
    st_nxt        = st_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    left_nxt      = left_r;
    rd_idx_nxt    = rd_idx_r;
    rd_j_nxt      = rd_j_r;
    rd_vld_nxt    = 1'b0;
    best_vld_nxt  = best_vld_r;
    best_cost_nxt = best_cost_r;
    best_j_nxt    = best_j_r;
    chosen_nxt    = chosen_r;
    case (st_r)
      S_IDLE: begin
        if (req.start) begin
          n_nxt        = req.n;
          k_nxt        = req.k;
          left_nxt     = req.k;
          rd_idx_nxt   = AW'(1);
          best_vld_nxt = 1'b0;
          if (req.k == '0) begin
            chosen_nxt = '0;
            st_nxt     = S_FIN;
          end else if (VC_W'(req.k) == req_n_m1) begin
            chosen_nxt = all_mask;
            st_nxt     = S_FIN;
          end else begin
            chosen_nxt = '0;
            st_nxt     = S_RUN;
          end
        end
      end
      S_RUN: begin
        // Issue one read a cycle, wrapping from N-1 back to vertex 1
        rd_idx_nxt = (rd_idx_r == last_idx) ? AW'(1) : rd_idx_r + AW'(1);
        rd_j_nxt   = rd_idx_r;
        rd_vld_nxt = 1'b1;
        if (take) begin
          best_vld_nxt  = 1'b1;
          best_cost_nxt = ram_rdata;
          best_j_nxt    = rd_j_r;
        end
        if (pass_end) begin
          chosen_nxt[cand_j] = 1'b1;
          best_vld_nxt       = 1'b0;
          left_nxt           = left_r - NG_W'(1);
          if (left_r == NG_W'(1)) begin
            st_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
      left_r     <= '0;
    end else begin
      st_r       <= st_nxt;
      rd_vld_r   <= rd_vld_nxt;
      best_vld_r <= best_vld_nxt;
      left_r     <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    rd_idx_r    <= rd_idx_nxt;
    rd_j_r      <= rd_j_nxt;
    best_cost_r <= best_cost_nxt;
    best_j_r    <= best_j_nxt;
    chosen_r    <= chosen_nxt;
  end

  assign rsp.done = (st_r == S_FIN);
  assign rsp.mask = MASK_W'(chosen_r);

  // A finished set holds exactly k vertices
  a_count_k: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN) |-> ($countones(chosen_r) == int'(k_r)))
    else $error("neighbour set size differs from k");

  // Passes remain whenever the engine runs
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RUN) |-> (left_r != '0))
    else $error("selection running with no passes left");

  // Each pass ends with a candidate found
  a_pass_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    pass_end |-> (best_vld_r || take))
    else $error("selection pass ended without a candidate");

endmodule
`default_nettype wire

/* sv/nearest_neighbor_set_builder.sv */
// Result: the request carrying the last cost of a row starts the selection; when k is 0
//   or k = N-1 the set needs no scan pass, else the engine makes k scan passes.
// Throughput: a row is loaded one cost a cycle, then the selection passes run over the
//   row memory's single read port; no cost is taken while they run or a finished set waits.
// Reset (synchronous, rst_n low): row 0, load position 1, vertex_count 64, ng_size 8.
//   The row memory is not cleared; every row overwrites the entries it uses.
`default_nettype none
module nearest_neighbor_set_builder #(
  parameter int MAX_VERTICES = nnsb_pkg::MAX_VERTICES_DEF,
  parameter int COST_BITS    = nnsb_pkg::COST_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  nnsb_in_if.sink                              in_ch,
  nnsb_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nnsb_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [nnsb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [nnsb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import nnsb_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SEL  = 3'b010,
    ST_HOLD = 3'b100
  } top_st_t;

  top_st_t                 st_r, st_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic [AW-1:0]           row_r, row_nxt;
  logic [ROW_W-1:0]        sel_row_r, sel_row_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]        out_row_r, out_row_nxt;
  logic [MASK_W-1:0]       out_mask_r, out_mask_nxt;

  cfg_t                    cfg;
  sel_req_t                sel_req;
  sel_rsp_t                sel_rsp;
  logic                    accept;
  logic                    row_end;
  logic [VC_W-1:0]         pos_inc;
  logic [VC_W-1:0]         row_inc;
  logic                    out_load;
  logic [COST_BITS+COST_W-1:0] cost_ext;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [COST_BITS-1:0]    ram_rdata;

  // Configuration registers
  nnsb_cfg #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Load side: store each cost at the current position of the row
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_LOAD);
  assign pos_inc  = VC_W'(pos_r) + VC_W'(1);
  assign row_inc  = VC_W'(row_r) + VC_W'(1);
  // The row ends at position N-1, or early if N shrank below the position
  assign row_end  = (pos_inc >= cfg.n);
  assign cost_ext = {{COST_BITS{1'b0}}, in_ch.cost};

  nnsb_ram #(
    .W     (COST_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_row_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (pos_r),
    .wdata (cost_ext[COST_BITS-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sel_req.start = accept && row_end;
  assign sel_req.n     = cfg.n;
  assign sel_req.k     = cfg.k;

  nnsb_select #(
    .MAX_VERTICES (MAX_VERTICES),
    .COST_BITS    (COST_BITS)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (sel_req),
    .rsp       (sel_rsp),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Move a finished set into the output register once it is free or draining;
  // the engine holds its mask while we wait
  assign out_load = ((st_r == ST_SEL && sel_rsp.done) || (st_r == ST_HOLD)) &&
                    (!out_valid_r || out_ch.ready);

  always_comb begin
    st_nxt        = st_r;
    pos_nxt       = pos_r;
    row_nxt       = row_r;
    sel_row_nxt   = sel_row_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_mask_nxt  = out_mask_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = sel_row_r;
      out_mask_nxt  = sel_rsp.mask;
    end

    case (st_r)
      ST_LOAD: begin
        if (accept) begin
          if (row_end) begin
            // Close the row: hand it to the engine and advance to the next vertex
            pos_nxt     = AW'(1);
            sel_row_nxt = ROW_W'(row_r);
            row_nxt     = (row_inc >= cfg.n) ? '0 : row_inc[AW-1:0];
            st_nxt      = ST_SEL;
          end else begin
            pos_nxt = pos_inc[AW-1:0];
          end
        end
      end
      ST_SEL: begin
        if (sel_rsp.done) begin
          st_nxt = out_load ? ST_LOAD : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          st_nxt = ST_LOAD;
        end
      end
      default: begin
        st_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      pos_r       <= AW'(1);
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pos_r       <= pos_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_row_r  <= sel_row_nxt;
    out_row_r  <= out_row_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.row_index     = out_row_r;
  assign out_ch.neighbor_mask = out_mask_r;

  // The engine only finishes a set that the load side handed over
  a_done_in_sel: assert property (@(posedge clk) disable iff (!rst_n)
    sel_rsp.done |-> (st_r == ST_SEL))
    else $error("selection finished outside the select phase");

  // The last cost of a row starts the selection
  a_row_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && row_end) |=> (st_r == ST_SEL))
    else $error("row end did not start selection");

  // Waiting on a set is only needed while the output register is occupied
  a_hold_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_HOLD) |-> out_valid_r)
    else $error("holding a set while the output register is empty");

endmodule
`default_nettype wire

/* tb/tb_nearest_neighbor_set_builder.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the nearest-neighbour set builder: streams cost rows, checks masks.
// Depends on nnsb_pkg, the nnsb_in_if and nnsb_out_if channels and the block itself.
module tb_nearest_neighbor_set_builder;
  import nnsb_pkg::*;

  localparam int MAX_V         = MAX_VERTICES_DEF;
  localparam int STREAM_ITEMS  = 1300;
  localparam int HOLD_CYCLES   = 400;
  // Slowest legal row: 62 scan passes over 63 entries, plus a full receiver hold-off
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 64;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [MASK_W-1:0] mask;
  } neighbour_set_t;

  // Predicts the neighbour set of every row and checks what the block emits
  class nearest_set_scoreboard;
    logic [COST_W-1:0] row_cost    [MAX_V];
    bit                ever_loaded [MAX_V];
    int unsigned       load_pos;
    int unsigned       row_now;
    logic [VC_W-1:0]   vc_reg;
    logic [NG_W-1:0]   ng_reg;
    neighbour_set_t    sets_due [$];
    int unsigned       errors;

    function new();
      foreach (row_cost[i]) begin
        row_cost[i]    = '0;
        ever_loaded[i] = 1'b0;
      end
      load_pos = 1;
      row_now  = 0;
      vc_reg   = VC_RESET;
      ng_reg   = NG_RESET;
      errors   = 0;
    endfunction

    function int unsigned clamp(int unsigned raw);
      if (raw < 2) return 2;
      if (raw > MAX_V) return MAX_V;
      return raw;
    endfunction

    function int unsigned vertices();
      return clamp(vc_reg);
    endfunction

    // Growing N mid-row must not expose entries that were never loaded
    function bit grow_is_safe(int unsigned n);
      if (load_pos == 1) return 1'b1;
      for (int unsigned i = 1; i < n; i++)
        if (!ever_loaded[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_VERTEX_COUNT: vc_reg = value[VC_W-1:0];
        REG_NG_SIZE:      ng_reg = value[NG_W-1:0];
        default: ;
      endcase
    endfunction

    // Rank every vertex 1..n-1; equal costs go to the lower index first
    function logic [MASK_W-1:0] nearest_mask(int unsigned n, int unsigned k);
      logic [MASK_W-1:0] mask;
      int unsigned       rank;
      mask = '0;
      for (int unsigned j = 1; j < n; j++) begin
        rank = 0;
        for (int unsigned i = 1; i < n; i++)
          if (row_cost[i] < row_cost[j] || (row_cost[i] == row_cost[j] && i < j)) rank++;
        if (rank < k) mask[j] = 1'b1;
      end
      return mask;
    endfunction

    function void note_cost(logic [COST_W-1:0] cost);
      int unsigned    n;
      int unsigned    k;
      int unsigned    slot;
      neighbour_set_t due;
      n    = vertices();
      slot = load_pos % MAX_V;
      row_cost[slot]    = cost;
      ever_loaded[slot] = 1'b1;
      if (load_pos + 1 < n) begin
        load_pos++;
        return;
      end
      // Row ends here, also early when N has shrunk below the load position
      k = (ng_reg > n - 1) ? n - 1 : ng_reg;
      due.row  = ROW_W'(row_now);
      due.mask = nearest_mask(n, k);
      sets_due.push_back(due);
      load_pos = 1;
      row_now  = (row_now + 1 >= n) ? 0 : row_now + 1;
    endfunction

    function void check_set(logic [ROW_W-1:0] row, logic [MASK_W-1:0] mask);
      neighbour_set_t due;
      if (sets_due.size() == 0) begin
        $display("%0t: neighbour set with none expected, got row %0d mask %h",
                 $time, row, mask);
        errors++;
        return;
      end
      due = sets_due.pop_front();
      if (row !== due.row) begin
        $display("%0t: row_index expected %0d, got %0d", $time, due.row, row);
        errors++;
      end
      if (mask !== due.mask) begin
        $display("%0t: neighbor_mask expected %h, got %h", $time, due.mask, mask);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bit                    steady;       // no idling on either side while set
  int unsigned           holds_asked;  // bumped by the stimulus to ask for a hold-off
  int unsigned           quiet;
  nearest_set_scoreboard board;

  nnsb_in_if  in_bus ();
  nnsb_out_if out_bus ();

  nearest_neighbor_set_builder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Offer one cost request, idling at random first; hold valid until it is taken
  task automatic send_cost(input logic [COST_W-1:0] cost);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 18) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.cost  <= cost;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    board.note_cost(cost);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    board.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, wait for every pending set, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (board.sets_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
  initial begin : receiver
    int unsigned stall_left;
    int unsigned holds_seen;
    stall_left    = 0;
    holds_seen    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != holds_asked) begin
        holds_seen = holds_asked;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(99) >= 18);
      end
    end
  end

  // Check every accepted set; end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        board.check_set(out_bus.row_index, out_bus.neighbor_mask);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
          (psel && penable && pwrite && pready === 1'b1)) begin
        quiet <= 0;
      end else if (quiet + 1 >= IDLE_LIMIT) begin
        $display("tb_nearest_neighbor_set_builder failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       pick;
    int unsigned       vc_raw;
    int unsigned       ng_raw;
    int unsigned       n;
    int unsigned       rows;
    int unsigned       count;
    logic [COST_W-1:0] cost;

    board        = new();
    rst_n        = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.cost  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady       = 1'b0;
    holds_asked  = 0;
    quiet        = 0;
    sent         = 0;
    phase        = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Four vertices, two nearest: saturated costs either side of a zero, then a three-way tie
    program_reg(REG_VERTEX_COUNT, 32'd4);
    program_reg(REG_NG_SIZE, 32'd2);
    send_cost(32'hFFFF_FFFF);
    send_cost(32'h0000_0000);
    send_cost(32'hFFFF_FFFF);
    repeat (3) send_cost(32'h0000_0005);

    // Empty neighbourhood
    settle();
    program_reg(REG_NG_SIZE, 32'd0);
    send_cost(32'd1);
    send_cost(32'd2);
    send_cost(32'd3);

    // Size beyond N-1 clips to every vertex; the row counter wraps after this row
    settle();
    program_reg(REG_NG_SIZE, 32'd63);
    send_cost(32'd7);
    send_cost(32'd1);
    send_cost(32'd4);

    // Vertex counts below two clamp to two: every cost is a row of its own
    settle();
    program_reg(REG_VERTEX_COUNT, 32'd0);
    send_cost(32'h8000_0000);
    send_cost(32'h0001_0000);
    settle();
    program_reg(REG_VERTEX_COUNT, 32'd1);
    send_cost(32'h7FFF_FFFF);

    // Shrink N part-way through a row: the next cost ends the row early
    settle();
    program_reg(REG_VERTEX_COUNT, 32'd10);
    program_reg(REG_NG_SIZE, 32'd3);
    send_cost(32'd9);
    send_cost(32'd3);
    send_cost(32'd3);
    send_cost(32'hFFFF_FFFF);
    send_cost(32'd0);
    settle();
    program_reg(REG_VERTEX_COUNT, 32'd5);
    send_cost(32'd2);

    // Random phases: new settings, a few whole rows, sometimes a partial row left open
    while (sent < STREAM_ITEMS) begin
      settle();
      pick = $urandom_range(99);
      if (pick < 55)      vc_raw = $urandom_range(12, 2);
      else if (pick < 75) vc_raw = $urandom_range(40, 13);
      else if (pick < 88) vc_raw = $urandom_range(63, 41);
      else if (pick < 93) vc_raw = 64;
      else if (pick < 96) vc_raw = $urandom_range(127, 65);
      else                vc_raw = $urandom_range(1, 0);
      // Hold N where growing it now would expose never-loaded entries
      if (board.clamp(vc_raw) > board.vertices() && !board.grow_is_safe(board.clamp(vc_raw)))
        vc_raw = board.vc_reg;
      n = board.clamp(vc_raw);

      pick = $urandom_range(99);
      if (pick < 15)      ng_raw = 0;
      else if (pick < 30) ng_raw = 63;
      else if (pick < 45) ng_raw = 1;
      else                ng_raw = $urandom_range(16, 2);

      // Upper data bits are random: only the low bits belong to the registers
      if ($urandom_range(1) == 0) begin
        program_reg(REG_VERTEX_COUNT, ($urandom() & 32'hFFFF_FF80) | vc_raw);
        program_reg(REG_NG_SIZE, ($urandom() & 32'hFFFF_FFC0) | ng_raw);
      end else begin
        program_reg(REG_NG_SIZE, ($urandom() & 32'hFFFF_FFC0) | ng_raw);
        program_reg(REG_VERTEX_COUNT, ($urandom() & 32'hFFFF_FF80) | vc_raw);
      end

      steady = (phase >= 8 && phase < 14);
      rows   = (n > 40) ? 1 : $urandom_range(6, 1);
      // Hold the receiver off while several rows keep coming, so the input backs up
      if (phase == 3 || phase == 30) begin
        holds_asked++;
        rows = 4;
      end
      count = rows * (n - 1);
      if ($urandom_range(3) == 0) count += $urandom_range(n - 2);

      repeat (count) begin
        pick = $urandom_range(99);
        if (pick < 30)      cost = COST_W'($urandom_range(3));
        else if (pick < 35) cost = '0;
        else if (pick < 40) cost = '1;
        else if (pick < 55) cost = {16'($urandom_range(3)), 16'($urandom())};
        else                cost = $urandom();
        send_cost(cost);
        sent++;
      end
      phase++;
    end

    // Drain, then give a stray result time to show up
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.errors == 0) begin
      $display("tb_nearest_neighbor_set_builder passed");
    end else begin
      $display("tb_nearest_neighbor_set_builder failed");
    end
    $finish;
  end

endmodule
